[hdl/lrusr_pkg.sv]
// ----------------------------------------------------------------------------
// lrusr_pkg
// Shared sizes, types and helpers of the LRU set replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrusr_pkg;

  localparam int WAYS     = 16;
  localparam int SETS     = 64;
  localparam int MAX_WAYS = 32;

  localparam int SET_IN_W = 6;
  localparam int WAY_IN_W = 4;
  localparam int MASK_W   = 16;

  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W  = RANK_W;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W  = WAYS * RANK_W;

  typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

  typedef struct packed {
    logic             inv_found;
    logic [WAY_W-1:0] inv_way;
    logic             lru_found;
    logic [WAY_W-1:0] lru_way;
  } victim_t;

  function automatic rank_row_t reset_row();
    rank_row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w] = RANK_W'(w);
    end
    return r;
  endfunction

  function automatic logic [SET_W-1:0] set_addr(input logic [SET_IN_W-1:0] s);
    return SET_W'(s);
  endfunction

endpackage

`default_nettype wire

[hdl/lrusr_ram.sv]
// ----------------------------------------------------------------------------
// lrusr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrusr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/lrusr_rank_logic.sv]
// ----------------------------------------------------------------------------
// lrusr_rank_logic
// Victim search and rank promotion over one set's rank row.
// ----------------------------------------------------------------------------
`default_nettype none

module lrusr_rank_logic import lrusr_pkg::*; (
  input  wire rank_row_t          row,
  input  wire logic [MASK_W-1:0]  valid_mask,
  input  wire logic [WAY_W-1:0]   way,
  output victim_t                 victim,
  output rank_row_t               row_next
);

  logic [MAX_WAYS-1:0] valid_ext;
  logic [RANK_W-1:0]   pivot;

  assign valid_ext = {{(MAX_WAYS-MASK_W){1'b1}}, valid_mask};
  assign pivot     = row[way];

  always_comb begin
    victim = '0;
    for (int w = WAYS-1; w >= 0; w--) begin
      if (!valid_ext[w]) begin
        victim.inv_found = 1'b1;
        victim.inv_way   = WAY_W'(w);
      end
      if (row[w] == RANK_W'(WAYS-1)) begin
        victim.lru_found = 1'b1;
        victim.lru_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        row_next[w] = '0;
      end else if (row[w] < pivot) begin
        row_next[w] = row[w] + 1'b1;
      end else begin
        row_next[w] = row[w];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/lru_set_replacement_unit.sv]
// ----------------------------------------------------------------------------
// lru_set_replacement_unit
// True-LRU replacement ranks for a set-associative cache.
// ----------------------------------------------------------------------------
// For each word, the set's rank row is read from a RAM with a registered
// read, then the victim or the promoted ranks are worked out and written
// back while busy is high; no new word is taken while busy is high. A
// victim query answers with done high for one cycle, rising as busy falls;
// the receiver cannot stall it. An update gives no answer. Rows never
// written read as their reset ranks through per-set valid flops, so no
// clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_set_replacement_unit import lrusr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode,
  input  wire logic [SET_IN_W-1:0] set_index,
  input  wire logic [WAY_IN_W-1:0] way_index,
  input  wire logic [MASK_W-1:0]   valid_mask,
  input  wire logic                hit,
  input  wire logic                is_writeback,
  output logic                     done,
  output logic [WAY_IN_W-1:0]      victim_way,
  output logic                     no_victim
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state;
  logic              accept;
  logic              mode_q;
  logic              set_ok;
  logic              upd_en;
  logic [SET_W-1:0]  set_q;
  logic [WAY_W-1:0]  way_q;
  logic [MASK_W-1:0] mask_q;
  logic              row_seen;
  logic [SETS-1:0]   row_valid;
  logic [ROW_W-1:0]  rdata;
  rank_row_t         row_cur;
  rank_row_t         row_next;
  victim_t           victim;
  logic              wr_en;
  logic              in_set_ok;
  logic              in_way_ok;

  assign accept    = start && !busy;
  assign in_set_ok = (32'(set_index) < SETS);
  assign in_way_ok = (32'(way_index) < WAYS);
  assign row_cur   = row_seen ? rank_row_t'(rdata) : reset_row();
  assign wr_en     = (state == S_EXEC) && upd_en;

  lrusr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(set_q),
    .wdata(ROW_W'(row_next)),
    .re   (accept),
    .raddr(set_addr(set_index)),
    .rdata(rdata)
  );

  lrusr_rank_logic u_rank (
    .row       (row_cur),
    .valid_mask(mask_q),
    .way       (way_q),
    .victim    (victim),
    .row_next  (row_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      done      <= 1'b0;
      row_valid <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_EXEC;
            busy     <= 1'b1;
            mode_q   <= mode;
            set_ok   <= in_set_ok;
            upd_en   <= mode && !(is_writeback && hit) && in_set_ok && in_way_ok;
            set_q    <= set_addr(set_index);
            way_q    <= WAY_W'(way_index);
            mask_q   <= valid_mask;
            row_seen <= row_valid[set_addr(set_index)];
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          if (upd_en) begin
            row_valid[set_q] <= 1'b1;
          end
          if (!mode_q) begin
            done <= 1'b1;
            if (victim.inv_found) begin
              victim_way <= WAY_IN_W'(victim.inv_way);
              no_victim  <= 1'b0;
            end else if (set_ok && victim.lru_found) begin
              victim_way <= WAY_IN_W'(victim.lru_way);
              no_victim  <= 1'b0;
            end else begin
              victim_way <= '0;
              no_victim  <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/lrusr_checker.sv]
// ----------------------------------------------------------------------------
// lrusr_checker
// Port-level timing checks of the LRU set replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lrusr_checker import lrusr_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                mode,
  input wire logic                done,
  input wire logic [WAY_IN_W-1:0] victim_way,
  input wire logic                no_victim
);

  // a word occupies exactly one busy cycle
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not follow an accepted word");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held beyond one cycle");

  // an answer only ever belongs to an earlier accepted query
  a_done_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !mode, 2))
    else $error("done without a matching query");

  a_no_victim: assert property (@(posedge clk) disable iff (rst)
    done && no_victim |-> victim_way == '0)
    else $error("no_victim with a non-zero way");

endmodule

bind lru_set_replacement_unit lrusr_checker u_lrusr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .mode      (mode),
  .done      (done),
  .victim_way(victim_way),
  .no_victim (no_victim)
);

`default_nettype wire
